[src/segmented_countdown_sequencer_core_assert.svh]
// Assertion macros for the countdown sequencer core.
// Included by the top level; no other dependencies.
`ifndef SEGMENTED_COUNTDOWN_SEQUENCER_CORE_ASSERT_SVH
`define SEGMENTED_COUNTDOWN_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTH
`define SCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scs assertion failed");
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scs assertion failed");
`else
`define SCS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/scs_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and item types of the countdown sequencer.
// No dependencies.
package scs_pkg;

    localparam int MAX_SEGMENTS_DEF = 8;
    localparam int SECONDS_BITS_DEF = 16;

    localparam int OPCODE_W   = 3;
    localparam int LOAD_IDX_W = 3;
    localparam int LOAD_SEC_W = 16;
    localparam int SEG_NOW_W  = 3;
    localparam int SEG_LEFT_W = 16;
    localparam int TASK_W     = 19;
    localparam int BEEP_W     = 3;
    localparam int PHASE_W    = 2;
    localparam int COUNT_W    = 4;

    localparam logic [TASK_W-1:0]  TASK_MAX    = '1;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd1;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RUN   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PAUSE = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

    localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_START  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TOGGLE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_SKIP   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ABORT  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 3'd5;

    // beep periods in seconds
    localparam int BEEP_P1 = 60;
    localparam int BEEP_P2 = 300;
    localparam int BEEP_P3 = 600;
    localparam int M1_W = $clog2(BEEP_P1);
    localparam int M2_W = $clog2(BEEP_P2);
    localparam int M3_W = $clog2(BEEP_P3);

    localparam int Q_DEPTH = 3;
    localparam int Q_PTR_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SEG_COUNT = 1'b0;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [LOAD_IDX_W-1:0] load_index;
        logic [LOAD_SEC_W-1:0] load_seconds;
    } t_in_item;

    typedef struct packed {
        logic              seg_chime;
        logic              fin_chime;
        logic [BEEP_W-1:0] beeps;
    } t_flags;

    typedef struct packed {
        logic [PHASE_W-1:0]    run_state;
        logic [SEG_NOW_W-1:0]  segment_now;
        logic [SEG_LEFT_W-1:0] segment_left;
        logic [TASK_W-1:0]     task_seconds;
        logic [TASK_W-1:0]     task_left;
        logic [TASK_W-1:0]     planned_total;
        logic                  segment_chime;
        logic                  finish_chime;
        logic [BEEP_W-1:0]     periodic_beeps;
    } t_result;

endpackage

[src/scs_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command items and result items.
// Depends on scs_pkg.
interface scs_in_if;
    logic                            valid;
    logic                            ready;
    logic [scs_pkg::OPCODE_W-1:0]    opcode;
    logic [scs_pkg::LOAD_IDX_W-1:0]  load_index;
    logic [scs_pkg::LOAD_SEC_W-1:0]  load_seconds;

    modport source (output valid, opcode, load_index, load_seconds, input ready);
    modport sink   (input valid, opcode, load_index, load_seconds, output ready);
endinterface

interface scs_out_if;
    logic                            valid;
    logic                            ready;
    logic [scs_pkg::PHASE_W-1:0]     run_state;
    logic [scs_pkg::SEG_NOW_W-1:0]   segment_now;
    logic [scs_pkg::SEG_LEFT_W-1:0]  segment_left;
    logic [scs_pkg::TASK_W-1:0]      task_seconds;
    logic [scs_pkg::TASK_W-1:0]      task_left;
    logic [scs_pkg::TASK_W-1:0]      planned_total;
    logic                            segment_chime;
    logic                            finish_chime;
    logic [scs_pkg::BEEP_W-1:0]      periodic_beeps;

    modport source (output valid, run_state, segment_now, segment_left, task_seconds,
                    task_left, planned_total, segment_chime, finish_chime,
                    periodic_beeps, input ready);
    modport sink   (input valid, run_state, segment_now, segment_left, task_seconds,
                    task_left, planned_total, segment_chime, finish_chime,
                    periodic_beeps, output ready);
endinterface

[src/scs_cfg.sv]
`timescale 1ns / 1ps
// APB register block: holds the segment count register.
// Depends on scs_pkg.
module scs_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [scs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [scs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [scs_pkg::COUNT_W-1:0]         o_seg_count
);
    import scs_pkg::*;

    logic               reg_sel;
    logic [COUNT_W-1:0] r_count;

    // word address; byte offset bits are ignored
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (psel && penable && pwrite && reg_sel == REG_SEG_COUNT) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SEG_COUNT: prdata = {{(APB_DATA_W-COUNT_W){1'b0}}, r_count};
            default:       prdata = '0;
        endcase
    end

    assign o_seg_count = r_count;

endmodule

[src/scs_engine.sv]
`timescale 1ns / 1ps
// Timer state, duration table with prefix sums, and per-item next-state logic.
// Depends on scs_pkg.
module scs_engine #(
    parameter  int MAX_SEGMENTS = scs_pkg::MAX_SEGMENTS_DEF,
    parameter  int SECONDS_BITS = scs_pkg::SECONDS_BITS_DEF,
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  scs_pkg::t_in_item             i_item,
    input  logic [scs_pkg::COUNT_W-1:0]   i_seg_count,
    output logic                          o_flags_valid,
    output scs_pkg::t_flags               o_flags,
    output logic [scs_pkg::PHASE_W-1:0]   o_phase,
    output logic [IW-1:0]                 o_idx,
    output logic [SECONDS_BITS-1:0]       o_seg_elapsed,
    output logic [scs_pkg::TASK_W-1:0]    o_task,
    output logic [SECONDS_BITS-1:0]       o_cur_dur,
    output logic                          o_has_seg,
    output logic [scs_pkg::TASK_W-1:0]    o_plan
);
    import scs_pkg::*;

    localparam int LW    = IW + 1;
    localparam int PRE_W = SECONDS_BITS + IW + 1;

    logic [SECONDS_BITS-1:0] r_dur [MAX_SEGMENTS];
    // r_pre[k] = sum of entries 0..k, kept exact (never overflows)
    logic [PRE_W-1:0]        r_pre [MAX_SEGMENTS];

    logic [PHASE_W-1:0]      r_phase, n_phase;
    logic [IW-1:0]           r_idx, n_idx;
    logic [SECONDS_BITS-1:0] r_se, n_se;
    logic [TASK_W-1:0]       r_te, n_te;
    logic [M1_W-1:0]         r_m1, n_m1;
    logic [M2_W-1:0]         r_m2, n_m2;
    logic [M3_W-1:0]         r_m3, n_m3;
    logic                    r_a_valid;
    t_flags                  r_flags, n_flags;

    logic [LW-1:0]           live;
    logic [LW-1:0]           live_m1;
    logic                    has_seg;
    logic                    at_last;
    logic [IW-1:0]           idx_inc;
    logic [SECONDS_BITS-1:0] cur_dur;
    logic [PRE_W-1:0]        plan_raw;
    logic [PRE_W+TASK_W-1:0] plan_ext;
    logic [TASK_W-1:0]       plan_now;
    logic [SECONDS_BITS-1:0] se_inc;
    logic                    te_step;
    logic                    done_now;
    logic [1:0]              hits;

    logic                    li_ok;
    logic [IW+LOAD_IDX_W-1:0] li_ext;
    logic [IW-1:0]           li_i;
    logic [SECONDS_BITS+LOAD_SEC_W-1:0] ls_ext;
    logic [SECONDS_BITS-1:0] ls_val;
    logic [PRE_W-1:0]        old_w, new_w;
    logic                    load_en;

    // live segment count: register value clipped to the table depth
    assign live    = (int'(i_seg_count) > MAX_SEGMENTS) ? LW'(MAX_SEGMENTS)
                                                         : LW'(i_seg_count);
    assign live_m1 = live - LW'(1);
    assign has_seg = {1'b0, r_idx} < live;
    assign at_last = ({1'b0, r_idx} + LW'(1)) >= live;
    assign idx_inc = r_idx + IW'(1);
    assign cur_dur = r_dur[r_idx];

    assign plan_raw = (live == '0) ? '0 : r_pre[live_m1[IW-1:0]];
    assign plan_ext = {{TASK_W{1'b0}}, plan_raw};
    assign plan_now = (plan_ext > {{PRE_W{1'b0}}, TASK_MAX}) ? TASK_MAX
                                                              : plan_ext[TASK_W-1:0];

    assign li_ok   = int'(i_item.load_index) < MAX_SEGMENTS;
    assign li_ext  = {{IW{1'b0}}, i_item.load_index};
    assign li_i    = li_ext[IW-1:0];
    assign ls_ext  = {{SECONDS_BITS{1'b0}}, i_item.load_seconds};
    assign ls_val  = ls_ext[SECONDS_BITS-1:0];
    assign old_w   = {{(IW+1){1'b0}}, r_dur[li_i]};
    assign new_w   = {{(IW+1){1'b0}}, ls_val};
    assign load_en = i_fire && (i_item.opcode == OP_LOAD) && li_ok;

    assign se_inc  = (r_se != {SECONDS_BITS{1'b1}}) ? r_se + SECONDS_BITS'(1) : r_se;
    assign te_step = (r_te != TASK_MAX);

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_se     = r_se;
        n_te     = r_te;
        n_m1     = r_m1;
        n_m2     = r_m2;
        n_m3     = r_m3;
        n_flags  = '0;
        done_now = 1'b0;
        hits     = '0;
        unique case (i_item.opcode)
            OP_TICK: begin
                if (r_phase == PH_RUN) begin
                    n_se = se_inc;
                    // mod counters follow task elapsed; they freeze at saturation
                    if (te_step) begin
                        n_te = r_te + TASK_W'(1);
                        n_m1 = (r_m1 == M1_W'(BEEP_P1 - 1)) ? '0 : r_m1 + M1_W'(1);
                        n_m2 = (r_m2 == M2_W'(BEEP_P2 - 1)) ? '0 : r_m2 + M2_W'(1);
                        n_m3 = (r_m3 == M3_W'(BEEP_P3 - 1)) ? '0 : r_m3 + M3_W'(1);
                    end
                    if (has_seg && se_inc >= cur_dur) begin
                        if (!at_last) begin
                            n_idx             = idx_inc;
                            n_se              = '0;
                            n_flags.seg_chime = 1'b1;
                        end else begin
                            n_se              = cur_dur;
                            n_phase           = PH_DONE;
                            n_flags.fin_chime = 1'b1;
                            done_now          = 1'b1;
                        end
                    end
                    if (!done_now) begin
                        hits = 2'(n_m1 == '0) + 2'(n_m2 == '0) + 2'(n_m3 == '0);
                        n_flags.beeps = {hits, 1'b0};
                        if (n_te >= plan_now) begin
                            n_phase           = PH_DONE;
                            n_flags.fin_chime = 1'b1;
                        end
                    end
                end
            end
            OP_START: begin
                n_phase = PH_RUN;
                n_idx   = '0;
                n_se    = '0;
                n_te    = '0;
                n_m1    = '0;
                n_m2    = '0;
                n_m3    = '0;
            end
            OP_TOGGLE: begin
                if (r_phase == PH_RUN) begin
                    n_phase = PH_PAUSE;
                end else if (r_phase == PH_PAUSE) begin
                    n_phase = PH_RUN;
                end
            end
            OP_SKIP: begin
                if (r_phase == PH_RUN) begin
                    n_flags.seg_chime = 1'b1;
                    if (!at_last) begin
                        n_idx = idx_inc;
                        n_se  = '0;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            OP_ABORT: begin
                if (r_phase == PH_RUN) begin
                    n_phase = PH_PAUSE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_idx     <= '0;
            r_se      <= '0;
            r_te      <= '0;
            r_m1      <= '0;
            r_m2      <= '0;
            r_m3      <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_fire;
            if (i_fire) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_se    <= n_se;
                r_te    <= n_te;
                r_m1    <= n_m1;
                r_m2    <= n_m2;
                r_m3    <= n_m3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_flags <= n_flags;
        end
    end

    // table cleared at reset so the prefix sums start consistent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                r_dur[k] <= '0;
                r_pre[k] <= '0;
            end
        end else if (load_en) begin
            r_dur[li_i] <= ls_val;
            for (int k = 0; k < MAX_SEGMENTS; k++) begin
                if (k >= int'(i_item.load_index)) begin
                    r_pre[k] <= r_pre[k] - old_w + new_w;
                end
            end
        end
    end

    assign o_flags_valid = r_a_valid;
    assign o_flags       = r_flags;
    assign o_phase       = r_phase;
    assign o_idx         = r_idx;
    assign o_seg_elapsed = r_se;
    assign o_task        = r_te;
    assign o_cur_dur     = cur_dur;
    assign o_has_seg     = has_seg;
    assign o_plan        = plan_now;

endmodule

[src/scs_report.sv]
`timescale 1ns / 1ps
// Builds the result item from the updated timer state and the item flags.
// Depends on scs_pkg.
module scs_report #(
    parameter  int MAX_SEGMENTS = scs_pkg::MAX_SEGMENTS_DEF,
    parameter  int SECONDS_BITS = scs_pkg::SECONDS_BITS_DEF,
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
    input  logic                          i_valid,
    input  scs_pkg::t_flags               i_flags,
    input  logic [scs_pkg::PHASE_W-1:0]   i_phase,
    input  logic [IW-1:0]                 i_idx,
    input  logic [SECONDS_BITS-1:0]       i_seg_elapsed,
    input  logic [scs_pkg::TASK_W-1:0]    i_task,
    input  logic [SECONDS_BITS-1:0]       i_cur_dur,
    input  logic                          i_has_seg,
    input  logic [scs_pkg::TASK_W-1:0]    i_plan,
    output logic                          o_push,
    output scs_pkg::t_result              o_result
);
    import scs_pkg::*;

    logic [SECONDS_BITS-1:0]            seg_left;
    logic [SECONDS_BITS+SEG_LEFT_W-1:0] seg_left_ext;
    logic [IW+SEG_NOW_W-1:0]            idx_ext;

    assign seg_left     = (i_has_seg && i_seg_elapsed < i_cur_dur)
                          ? i_cur_dur - i_seg_elapsed : '0;
    assign seg_left_ext = {{SEG_LEFT_W{1'b0}}, seg_left};
    assign idx_ext      = {{SEG_NOW_W{1'b0}}, i_idx};

    always_comb begin
        o_result.run_state      = i_phase;
        o_result.segment_now    = idx_ext[SEG_NOW_W-1:0];
        o_result.segment_left   = seg_left_ext[SEG_LEFT_W-1:0];
        o_result.task_seconds   = i_task;
        o_result.task_left      = (i_task >= i_plan) ? '0 : i_plan - i_task;
        o_result.planned_total  = i_plan;
        o_result.segment_chime  = i_flags.seg_chime;
        o_result.finish_chime   = i_flags.fin_chime;
        o_result.periodic_beeps = i_flags.beeps;
    end

    assign o_push = i_valid;

endmodule

[src/scs_outq.sv]
`timescale 1ns / 1ps
// Three-entry result queue; tells the input side when an item may enter.
// Depends on scs_pkg.
module scs_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  scs_pkg::t_result  i_data,
    input  logic              i_ready,
    output logic              o_valid,
    output scs_pkg::t_result  o_data,
    output logic              o_room
);
    import scs_pkg::*;

    t_result              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr, r_rd;
    logic [Q_PTR_W-1:0]   r_cnt;
    logic                 pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];
    assign pop     = o_valid && i_ready;
    // one item may still be in flight from the engine register
    assign o_room  = ({1'b0, r_cnt} + {{Q_PTR_W{1'b0}}, i_push}) <= (Q_PTR_W+1)'(Q_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + Q_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + Q_PTR_W'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

[src/segmented_countdown_sequencer_core.sv]
`timescale 1ns / 1ps
// Top level of the segmented countdown sequencer.
// Depends on scs_pkg, scs_if, scs_cfg, scs_engine, scs_report, scs_outq.
//
//  channel   dir  handshake            payload
//  i_in      in   valid/ready          opcode, load_index, load_seconds
//  o_out     out  valid/ready          run_state ... periodic_beeps
//  apb       in   psel/penable/pready  paddr, pwdata, prdata (segment_count)
//
// One item per cycle while the result queue has room; after its item is accepted, a
// result passes through the engine state register, then the result queue.
// Reset is synchronous, active low; the duration table clears with it.
// The result queue holds three items; i_in.ready drops only when the queue plus
// the item in flight would fill it, so a stalled sink stops the input side.
module segmented_countdown_sequencer_core #(
    parameter  int MAX_SEGMENTS = scs_pkg::MAX_SEGMENTS_DEF,
    parameter  int SECONDS_BITS = scs_pkg::SECONDS_BITS_DEF,
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    scs_in_if.sink                          i_in,
    scs_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [scs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [scs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [scs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import scs_pkg::*;

`include "segmented_countdown_sequencer_core_assert.svh"

    logic                    w_in_fire;
    logic                    w_in_ready;
    t_in_item                w_item;
    logic [COUNT_W-1:0]      w_seg_count;
    logic                    w_flags_valid;
    t_flags                  w_flags;
    logic [PHASE_W-1:0]      w_phase;
    logic [IW-1:0]           w_idx;
    logic [SECONDS_BITS-1:0] w_seg_elapsed;
    logic [TASK_W-1:0]       w_task;
    logic [SECONDS_BITS-1:0] w_cur_dur;
    logic                    w_has_seg;
    logic [TASK_W-1:0]       w_plan;
    logic                    w_push;
    t_result                 w_result;
    t_result                 w_head;

    assign w_item.opcode       = i_in.opcode;
    assign w_item.load_index   = i_in.load_index;
    assign w_item.load_seconds = i_in.load_seconds;
    assign i_in.ready          = w_in_ready;
    assign w_in_fire           = i_in.valid && w_in_ready;

    scs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_seg_count (w_seg_count)
    );

    scs_engine #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SECONDS_BITS (SECONDS_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_in_fire),
        .i_item        (w_item),
        .i_seg_count   (w_seg_count),
        .o_flags_valid (w_flags_valid),
        .o_flags       (w_flags),
        .o_phase       (w_phase),
        .o_idx         (w_idx),
        .o_seg_elapsed (w_seg_elapsed),
        .o_task        (w_task),
        .o_cur_dur     (w_cur_dur),
        .o_has_seg     (w_has_seg),
        .o_plan        (w_plan)
    );

    scs_report #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .SECONDS_BITS (SECONDS_BITS)
    ) u_report (
        .i_valid       (w_flags_valid),
        .i_flags       (w_flags),
        .i_phase       (w_phase),
        .i_idx         (w_idx),
        .i_seg_elapsed (w_seg_elapsed),
        .i_task        (w_task),
        .i_cur_dur     (w_cur_dur),
        .i_has_seg     (w_has_seg),
        .i_plan        (w_plan),
        .o_push        (w_push),
        .o_result      (w_result)
    );

    scs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_ready (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (w_head),
        .o_room  (w_in_ready)
    );

    assign o_out.run_state      = w_head.run_state;
    assign o_out.segment_now    = w_head.segment_now;
    assign o_out.segment_left   = w_head.segment_left;
    assign o_out.task_seconds   = w_head.task_seconds;
    assign o_out.task_left      = w_head.task_left;
    assign o_out.planned_total  = w_head.planned_total;
    assign o_out.segment_chime  = w_head.segment_chime;
    assign o_out.finish_chime   = w_head.finish_chime;
    assign o_out.periodic_beeps = w_head.periodic_beeps;

    // every accepted item reaches the report stage in the next cycle
    `SCS_ASSERT_NEXT(a_fire_reaches_report, i_clk, i_rst_n, w_in_fire, w_flags_valid)
    `SCS_ASSERT_IMP(a_finish_means_done, i_clk, i_rst_n, w_flags_valid && w_flags.fin_chime, w_phase == PH_DONE)
    `SCS_ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, w_in_fire && i_in.opcode == OP_START, w_phase == PH_RUN && w_seg_elapsed == '0 && w_task == '0)
    // input stalls only while results are pending
    `SCS_ASSERT_IMP(a_stall_has_cause, i_clk, i_rst_n, !w_in_ready, o_out.valid || w_flags_valid)

endmodule

[test/scs_status_checker.sv]
`timescale 1ns / 1ps
// Status checker for the countdown sequencer: follows accepted command items and
// segment_count writes, predicts each status item and compares it at the output.
// Depends on scs_pkg and scs_if.
module scs_status_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    scs_in_if                              in_ch,
    scs_out_if                             out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [scs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [scs_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import scs_pkg::*;

    localparam int MAX_SEG = MAX_SEGMENTS_DEF;
    localparam logic [APB_ADDR_W-1:0] SEG_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_SEG_COUNT));

    logic [SEG_LEFT_W-1:0] dur_tbl [MAX_SEG];
    logic [PHASE_W-1:0]    phase_r;
    logic [SEG_NOW_W-1:0]  seg_idx_r;
    logic [SEG_LEFT_W-1:0] seg_el_r;
    logic [TASK_W-1:0]     task_el_r;
    logic [COUNT_W-1:0]    seg_count_r;

    t_result status_due_q[$];
    int      fail_cnt;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // counts above the table size act as a full table
    function automatic int active_segments();
        return (int'(seg_count_r) > MAX_SEG) ? MAX_SEG : int'(seg_count_r);
    endfunction

    function automatic logic [TASK_W-1:0] plan_total();
        int unsigned acc;
        acc = 0;
        for (int k = 0; k < active_segments(); k++)
            acc += dur_tbl[k];
        return (acc > TASK_MAX) ? TASK_MAX : acc[TASK_W-1:0];
    endfunction

    // moves to the next segment, or completes the task when none is left
    function automatic bit advance_segment();
        if (int'(seg_idx_r) + 1 < active_segments()) begin
            seg_idx_r = seg_idx_r + 1'b1;
            seg_el_r  = '0;
            return 1'b1;
        end
        phase_r = PH_DONE;
        return 1'b0;
    endfunction

    function automatic t_result timer_step(t_in_item cmd);
        t_result               r;
        logic [TASK_W-1:0]     plan;
        logic [SEG_LEFT_W-1:0] cur_dur;
        bit                    done_now;
        r        = '0;
        done_now = 1'b0;
        case (cmd.opcode)
            OP_TICK: begin
                if (phase_r == PH_RUN) begin
                    if (seg_el_r != '1)
                        seg_el_r = seg_el_r + 1'b1;
                    if (task_el_r != TASK_MAX)
                        task_el_r = task_el_r + 1'b1;
                    if (seg_idx_r < active_segments()) begin
                        cur_dur = dur_tbl[seg_idx_r];
                        if (seg_el_r >= cur_dur) begin
                            seg_el_r = cur_dur;
                            if (advance_segment()) begin
                                r.segment_chime = 1'b1;
                            end else begin
                                r.finish_chime = 1'b1;
                                done_now       = 1'b1;
                            end
                        end
                    end
                    // a tick that ends the last segment asks for no beeps
                    if (!done_now) begin
                        if (task_el_r != '0) begin
                            if (task_el_r % BEEP_P1 == 0)
                                r.periodic_beeps += 3'd2;
                            if (task_el_r % BEEP_P2 == 0)
                                r.periodic_beeps += 3'd2;
                            if (task_el_r % BEEP_P3 == 0)
                                r.periodic_beeps += 3'd2;
                        end
                        if (task_el_r >= plan_total()) begin
                            phase_r        = PH_DONE;
                            r.finish_chime = 1'b1;
                        end
                    end
                end
            end
            OP_START: begin
                phase_r   = PH_RUN;
                seg_idx_r = '0;
                seg_el_r  = '0;
                task_el_r = '0;
            end
            OP_TOGGLE: begin
                if (phase_r == PH_RUN)
                    phase_r = PH_PAUSE;
                else if (phase_r == PH_PAUSE)
                    phase_r = PH_RUN;
            end
            OP_SKIP: begin
                if (phase_r == PH_RUN) begin
                    r.segment_chime = 1'b1;
                    void'(advance_segment());
                end
            end
            OP_ABORT: begin
                if (phase_r == PH_RUN)
                    phase_r = PH_PAUSE;
            end
            OP_LOAD: begin
                if (cmd.load_index < MAX_SEG)
                    dur_tbl[cmd.load_index] = cmd.load_seconds;
            end
            default: ;
        endcase

        plan = plan_total();
        if (seg_idx_r < active_segments()) begin
            cur_dur = dur_tbl[seg_idx_r];
            r.segment_left = (seg_el_r >= cur_dur) ? '0 : cur_dur - seg_el_r;
        end
        r.run_state     = phase_r;
        r.segment_now   = seg_idx_r;
        r.task_seconds  = task_el_r;
        r.task_left     = (task_el_r >= plan) ? '0 : plan - task_el_r;
        r.planned_total = plan;
        return r;
    endfunction

    task automatic flag_field(input string name, input longint unsigned want_v,
                              input longint unsigned got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
        fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_in_item cmd;
        t_result  want;
        t_result  got;
        if (!i_rst_n) begin
            foreach (dur_tbl[k])
                dur_tbl[k] = '0;
            phase_r     = PH_IDLE;
            seg_idx_r   = '0;
            seg_el_r    = '0;
            task_el_r   = '0;
            seg_count_r = COUNT_RESET;
            status_due_q.delete();
            fail_cnt    = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == SEG_COUNT_ADDR)
                seg_count_r = pwdata[COUNT_W-1:0];
            if (in_ch.valid && in_ch.ready) begin
                cmd.opcode       = in_ch.opcode;
                cmd.load_index   = in_ch.load_index;
                cmd.load_seconds = in_ch.load_seconds;
                status_due_q.push_back(timer_step(cmd));
            end
            if (out_ch.valid && out_ch.ready) begin
                got.run_state      = out_ch.run_state;
                got.segment_now    = out_ch.segment_now;
                got.segment_left   = out_ch.segment_left;
                got.task_seconds   = out_ch.task_seconds;
                got.task_left      = out_ch.task_left;
                got.planned_total  = out_ch.planned_total;
                got.segment_chime  = out_ch.segment_chime;
                got.finish_chime   = out_ch.finish_chime;
                got.periodic_beeps = out_ch.periodic_beeps;
                if (status_due_q.size() == 0) begin
                    $display("%0t: status item with none expected, actual %p", $time, got);
                    fail_cnt++;
                end else begin
                    want = status_due_q.pop_front();
                    if (got.run_state !== want.run_state)
                        flag_field("run_state", want.run_state, got.run_state);
                    if (got.segment_now !== want.segment_now)
                        flag_field("segment_now", want.segment_now, got.segment_now);
                    if (got.segment_left !== want.segment_left)
                        flag_field("segment_left", want.segment_left, got.segment_left);
                    if (got.task_seconds !== want.task_seconds)
                        flag_field("task_seconds", want.task_seconds, got.task_seconds);
                    if (got.task_left !== want.task_left)
                        flag_field("task_left", want.task_left, got.task_left);
                    if (got.planned_total !== want.planned_total)
                        flag_field("planned_total", want.planned_total, got.planned_total);
                    if (got.segment_chime !== want.segment_chime)
                        flag_field("segment_chime", want.segment_chime, got.segment_chime);
                    if (got.finish_chime !== want.finish_chime)
                        flag_field("finish_chime", want.finish_chime, got.finish_chime);
                    if (got.periodic_beeps !== want.periodic_beeps)
                        flag_field("periodic_beeps", want.periodic_beeps, got.periodic_beeps);
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= status_due_q.size();
    end

endmodule

[test/tb_segmented_countdown_sequencer_core.sv]
`timescale 1ns / 1ps
// Testbench top for the countdown sequencer: drives command items and
// segment_count writes under several idling patterns and gives the verdict.
// Depends on scs_pkg, scs_if, scs_status_checker and the core.
module tb_segmented_countdown_sequencer_core;
    import scs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 10;
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd7;
    localparam logic [APB_ADDR_W-1:0] SEG_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_SEG_COUNT));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_cnt     = 0;
    int sent_cnt      = 0;
    int fail_count;
    int pending;

    scs_in_if  in_ch ();
    scs_out_if out_ch ();

    segmented_countdown_sequencer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    scs_status_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        cycle_cnt    <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL segmented_countdown_sequencer_core");
            $finish;
        end
    end

    // valid stays high across back-to-back items; it only drops inside a gap
    task automatic send_item(input logic [OPCODE_W-1:0] op, input int idx, input int sec);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.load_index   <= LOAD_IDX_W'(idx);
        in_ch.load_seconds <= LOAD_SEC_W'(sec);
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sent_cnt++;
    endtask

    // hold the sender until every status item is back, plus pipeline slack
    task automatic settle_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seg_count(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SEG_COUNT_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return $urandom_range(9, 15);
        return $urandom_range(1, 8);
    endfunction

    // short durations keep segment changes and completions frequent
    function automatic int pick_seconds();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return $urandom_range(0, 65535);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_random();
        int roll;
        int idx;
        int sec;
        roll = $urandom_range(99);
        idx  = $urandom_range(0, 7);
        sec  = $urandom_range(0, 65535);
        if (roll < 66)
            send_item(OP_TICK, idx, sec);
        else if (roll < 74)
            send_item(OP_TOGGLE, idx, sec);
        else if (roll < 81)
            send_item(OP_SKIP, idx, sec);
        else if (roll < 85)
            send_item(OP_ABORT, idx, sec);
        else if (roll < 92)
            send_item(OP_LOAD, idx, pick_seconds());
        else if (roll < 96)
            send_item(OP_START, idx, sec);
        else
            send_item(roll[0] ? OP_SPARE_A : OP_SPARE_B, idx, sec);
    endtask

    task automatic random_sequence();
        int body_len;
        int hold_at;
        settle_results();
        write_seg_count(pick_count());
        repeat ($urandom_range(0, 3))
            send_item(OP_LOAD, $urandom_range(0, 7), pick_seconds());
        send_item(OP_START, $urandom_range(0, 7), $urandom_range(0, 65535));
        body_len = $urandom_range(10, 40);
        hold_at  = $urandom_range(0, 4 * body_len);
        for (int k = 0; k < body_len; k++) begin
            if (k == hold_at)
                settle_results();
            send_random();
        end
    endtask

    task automatic directed_checks();
        // entry zero goes first so no status ever sums an unwritten entry
        send_item(OP_LOAD, 0, 3);
        send_item(OP_LOAD, 1, 2);
        send_item(OP_LOAD, 2, 0);
        send_item(OP_LOAD, 3, 16'hFFFF);
        send_item(OP_LOAD, 4, 1);
        send_item(OP_LOAD, 5, 16'h8000);
        send_item(OP_LOAD, 6, 16'h7FFF);
        send_item(OP_LOAD, 7, 16'hFFFF);
        send_item(OP_START, 0, 0);
        send_item(OP_SPARE_A, 0, 0);
        send_item(OP_SPARE_B, 7, 16'hFFFF);
        send_item(OP_TICK, 0, 0);
        send_item(OP_TOGGLE, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_ABORT, 0, 0);
        send_item(OP_TOGGLE, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_SKIP, 0, 0);
        send_item(OP_TOGGLE, 0, 0);
        send_item(OP_ABORT, 0, 0);
        send_item(OP_TICK, 0, 0);

        // empty task: tick finishes with the finish chime, skip with only the segment chime
        settle_results();
        write_seg_count(0);
        send_item(OP_START, 0, 0);
        send_item(OP_TICK, 0, 0);
        send_item(OP_START, 0, 0);
        send_item(OP_SKIP, 0, 0);

        // oversized count, then lower it under the current segment mid-run
        settle_results();
        write_seg_count(15);
        send_item(OP_START, 0, 0);
        send_item(OP_ABORT, 0, 0);
        send_item(OP_TOGGLE, 0, 0);
        send_item(OP_SKIP, 0, 0);
        send_item(OP_SKIP, 0, 0);
        send_item(OP_SKIP, 0, 0);
        settle_results();
        write_seg_count(2);
        repeat (5) send_item(OP_TICK, 0, 0);
    endtask

    // crosses several 60 s marks, a segment change and the 300 s mark mid-task
    task automatic long_run();
        settle_results();
        write_seg_count(2);
        send_item(OP_LOAD, 0, 200);
        send_item(OP_LOAD, 1, 200);
        send_item(OP_START, 0, 0);
        repeat (300) send_item(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 65535));
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_TICK;
        in_ch.load_index   = '0;
        in_ch.load_seconds = '0;
        out_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_checks();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            sent_cnt = 0;
            while (sent_cnt < ITEMS_PER_PHASE)
                random_sequence();
            if (ph == 0)
                long_run();
        end

        settle_results();
        if (fail_count == 0 && pending == 0)
            $display("PASS segmented_countdown_sequencer_core");
        else
            $display("FAIL segmented_countdown_sequencer_core");
        $finish;
    end

endmodule
